// ===== rtl/sstcq_pkg.sv =====
// Shared constants, opcodes and controller/datapath interface types for the
// stamped slot two-class queue. No dependencies.
package sstcq_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int STAMP_W = 32;
  localparam int SRC_W   = 4;
  localparam int REQ_W   = 31;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last;
  } stat_t;

endpackage

// ===== rtl/stamped_slot_two_class_queue.sv =====
// Top level of the stamped slot two-class queue.
// Joins sstcq_ctrl and sstcq_datapath; uses sstcq_pkg.
//
// Raise start with a word while busy is low; the word is taken at that edge.
// Each word is finished before the next can be accepted: the controller
// scans the slot table one slot per cycle, then commits and presents the
// result. The result is valid on the output ports for exactly the one
// cycle in which done is high and cannot be held off, so the receiver must
// capture it then. Flags report the table as it stands after the word.
module stamped_slot_two_class_queue
  import sstcq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             opcode,
  input  logic [SRC_W-1:0] entry_source,
  input  logic [REQ_W-1:0] entry_request,
  input  logic             take_class,
  output logic             done,
  output logic             accepted,
  output logic [SRC_W-1:0] out_source,
  output logic [REQ_W-1:0] out_request,
  output logic             is_full,
  output logic             class0_empty,
  output logic             class1_empty
);

  cmd_t  cmd;
  stat_t stat;

  sstcq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  sstcq_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .opcode        (opcode),
    .entry_source  (entry_source),
    .entry_request (entry_request),
    .take_class    (take_class),
    .stat          (stat),
    .accepted      (accepted),
    .out_source    (out_source),
    .out_request   (out_request),
    .is_full       (is_full),
    .class0_empty  (class0_empty),
    .class1_empty  (class1_empty)
  );

endmodule

// ===== rtl/sstcq_ctrl.sv =====
// Controller state machine of the stamped slot two-class queue.
// Sequences load, slot scan, commit and result strobe; uses sstcq_pkg.
module sstcq_ctrl
  import sstcq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start) state_next = S_SCAN;
      S_SCAN:   if (stat.last) state_next = S_COMMIT;
      S_COMMIT: state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy       = (state != S_IDLE);
  assign done       = (state == S_DONE);
  assign cmd.load   = (state == S_IDLE) && start;
  assign cmd.step   = (state == S_SCAN);
  assign cmd.commit = (state == S_COMMIT);

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");
  a_load_scans: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (cmd.step && busy))
    else $error("accepted word did not start a scan");

endmodule

// ===== rtl/sstcq_datapath.sv =====
// Datapath of the stamped slot two-class queue: slot table, stamp counter,
// one-slot-per-cycle scan and result registers; uses sstcq_pkg.
module sstcq_datapath
  import sstcq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic             opcode,
  input  logic [SRC_W-1:0] entry_source,
  input  logic [REQ_W-1:0] entry_request,
  input  logic             take_class,
  output stat_t            stat,
  output logic             accepted,
  output logic [SRC_W-1:0] out_source,
  output logic [REQ_W-1:0] out_request,
  output logic             is_full,
  output logic             class0_empty,
  output logic             class1_empty
);

  logic               op_r;
  logic               cls_r;
  logic [SRC_W-1:0]   src_r;
  logic [REQ_W-1:0]   req_r;
  logic [SLOT_W-1:0]  idx;
  logic               found;
  logic [SLOT_W-1:0]  best;
  logic [STAMP_W-1:0] best_stamp;
  logic [STAMP_W-1:0] counter;
  logic [STAMP_W-1:0] counter_next;
  logic [SLOTS-1:0]   occ;
  logic [SLOTS-1:0]   klass;
  logic [STAMP_W-1:0] stamp [SLOTS];
  logic [SRC_W-1:0]   mem_src [SLOTS];
  logic [REQ_W-1:0]   mem_req [SLOTS];
  logic [SRC_W-1:0]   rd_src;
  logic [REQ_W-1:0]   rd_req;
  logic [STAMP_W-1:0] cur_stamp;
  logic               hit;
  logic               add_wr;
  logic               take_hit;

  assign counter_next = (counter == '1) ? STAMP_W'(1) : counter + STAMP_W'(1);
  assign add_wr       = cmd.commit && found && (op_r == OP_ADD);

  always_comb begin
    if (op_r == OP_ADD) begin
      hit = !found && !occ[idx];
    end else begin
      hit = occ[idx] && (klass[idx] == cls_r) && (!found || (cur_stamp < best_stamp));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ     <= '0;
      counter <= '0;
      found   <= 1'b0;
      idx     <= '0;
    end else if (cmd.load) begin
      idx   <= '0;
      found <= 1'b0;
    end else if (cmd.step) begin
      if (hit) begin
        found <= 1'b1;
      end
      idx <= idx + SLOT_W'(1);
    end else if (cmd.commit && found) begin
      if (op_r == OP_ADD) begin
        counter   <= counter_next;
        occ[best] <= 1'b1;
      end else begin
        occ[best] <= 1'b0;
      end
    end
  end

  // hold the word and the running best
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= opcode;
      cls_r <= take_class;
      src_r <= entry_source;
      req_r <= entry_request;
    end
    if (cmd.step && hit) begin
      best       <= idx;
      best_stamp <= cur_stamp;
    end
  end

  // fetch the stamp of the slot scanned next
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_stamp <= stamp[SLOT_W'(0)];
    end else if (cmd.step) begin
      cur_stamp <= stamp[idx + SLOT_W'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (add_wr) begin
      stamp[best]   <= counter_next;
      klass[best]   <= req_r[0];
      mem_src[best] <= src_r;
      mem_req[best] <= req_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rd_src <= mem_src[best];
      rd_req <= mem_req[best];
    end
  end

  assign take_hit     = (op_r == OP_TAKE) && found;
  assign stat.last    = (idx == SLOT_W'(SLOTS - 1));
  assign accepted     = found;
  assign out_source   = take_hit ? rd_src : '0;
  assign out_request  = take_hit ? rd_req : '0;
  assign is_full      = &occ;
  assign class0_empty = !(|(occ & ~klass));
  assign class1_empty = !(|(occ & klass));

  a_add_free: assert property (@(posedge clk) disable iff (rst)
    add_wr |-> !occ[best])
    else $error("add wrote an occupied slot");
  a_take_frees: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && take_hit) |=> !occ[best])
    else $error("take did not free its slot");
  a_stamp_nonzero: assert property (@(posedge clk) disable iff (rst)
    add_wr |=> (counter != '0))
    else $error("stamp counter reached zero after an add");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for stamped_slot_two_class_queue: directed and random add/take
// words, each checked against a slot-table predictor held in a small scoreboard class.
// Depends on sstcq_pkg and the stamped_slot_two_class_queue RTL.
module tb_top;
  import sstcq_pkg::*;

  typedef struct packed {
    logic             accepted;
    logic [SRC_W-1:0] source;
    logic [REQ_W-1:0] request;
    logic             full;
    logic             class0_empty;
    logic             class1_empty;
  } reply_t;

  class slot_queue_board;
    bit [STAMP_W-1:0] stamps [SLOTS];
    bit [SRC_W-1:0]   held_source [SLOTS];
    bit [REQ_W-1:0]   held_request [SLOTS];
    bit [STAMP_W-1:0] stamp_now;
    reply_t           due_replies [$];
    int               errors;

    function int open_slot();
      for (int i = 0; i < SLOTS; i++) begin
        if (stamps[i] == 0) return i;
      end
      return -1;
    endfunction

    function int oldest_of(bit cls);
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (stamps[i] != 0 && held_request[i][0] == cls &&
            (best < 0 || stamps[i] < stamps[best])) best = i;
      end
      return best;
    endfunction

    function void note_word(logic op, logic [SRC_W-1:0] src, logic [REQ_W-1:0] req,
                            logic cls);
      reply_t r;
      int s;
      r = '0;
      if (op == OP_ADD) begin
        s = open_slot();
        if (s >= 0) begin
          stamp_now = (stamp_now == '1) ? STAMP_W'(1) : stamp_now + 1'b1;
          held_source[s] = src;
          held_request[s] = req;
          stamps[s] = stamp_now;
          r.accepted = 1'b1;
        end
      end else begin
        s = oldest_of(cls);
        if (s >= 0) begin
          r.source = held_source[s];
          r.request = held_request[s];
          stamps[s] = 0;
          r.accepted = 1'b1;
        end
      end
      r.full = (open_slot() < 0);
      r.class0_empty = (oldest_of(1'b0) < 0);
      r.class1_empty = (oldest_of(1'b1) < 0);
      due_replies.push_back(r);
    endfunction

    function void match_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t mismatch %s: expected %0h actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_word(reply_t got);
      reply_t want;
      if (due_replies.size() == 0) begin
        $display("%0t unexpected result: expected none actual %0h", $time, got);
        errors++;
        return;
      end
      want = due_replies.pop_front();
      match_field("accepted", want.accepted, got.accepted);
      match_field("out_source", want.source, got.source);
      match_field("out_request", want.request, got.request);
      match_field("is_full", want.full, got.full);
      match_field("class0_empty", want.class0_empty, got.class0_empty);
      match_field("class1_empty", want.class1_empty, got.class1_empty);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic             opcode = OP_ADD;
  logic [SRC_W-1:0] entry_source = '0;
  logic [REQ_W-1:0] entry_request = '0;
  logic             take_class = 1'b0;
  logic             done;
  logic             accepted;
  logic [SRC_W-1:0] out_source;
  logic [REQ_W-1:0] out_request;
  logic             is_full;
  logic             class0_empty;
  logic             class1_empty;

  slot_queue_board board;

  stamped_slot_two_class_queue dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done)
      board.check_word(reply_t'{accepted, out_source, out_request, is_full,
                                class0_empty, class1_empty});
  end

  // hold start high until the word is taken; start stays high on return
  task automatic send_word(input logic op, input logic [SRC_W-1:0] src,
                           input logic [REQ_W-1:0] req, input logic cls);
    start <= 1'b1;
    opcode <= op;
    entry_source <= src;
    entry_request <= req;
    take_class <= cls;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_word(op, src, req, cls);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (board.due_replies.size() != 0) @(posedge clk);
  endtask

  task automatic random_word(input int add_pct);
    logic op;
    op = ($urandom_range(99) < add_pct) ? OP_ADD : OP_TAKE;
    send_word(op, SRC_W'($urandom_range(15)), REQ_W'($urandom), 1'($urandom_range(1)));
  endtask

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [REQ_W-1:0] req;
    int add_pct;
    int idle_pct;
    int phase_idle [4];
    phase_idle = '{0, 63, 0, 22};
    board = new();
    add_pct = 50;
    idle_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_word(OP_TAKE, '1, '1, 1'b0);
    send_word(OP_TAKE, '0, '0, 1'b1);
    for (int i = 0; i < SLOTS; i++) begin
      req = REQ_W'($urandom);
      req[0] = i[0];
      if (i == 0) req = '0;
      if (i == SLOTS - 1) req = '1;
      send_word(OP_ADD, SRC_W'(i), req, i[0]);
    end
    // drop: table full
    send_word(OP_ADD, 4'ha, REQ_W'($urandom), 1'b0);
    send_word(OP_TAKE, '0, '0, 1'b1);
    send_word(OP_TAKE, '0, '0, 1'b0);
    send_word(OP_TAKE, '1, '1, 1'b1);
    send_word(OP_ADD, 4'h5, REQ_W'($urandom), 1'b1);
    send_word(OP_TAKE, '0, '1, 1'b0);
    send_word(OP_TAKE, '1, '0, 1'b0);
    settle();

    foreach (phase_idle[p]) begin
      for (int n = 0; n < 350; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(2))
            0: add_pct = 15;
            1: add_pct = 50;
            default: add_pct = 85;
          endcase
          idle_pct = ($urandom_range(3) == 0) ? 0 : phase_idle[p];
        end
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
          hold_off($urandom_range(1, 24));
        random_word(add_pct);
      end
      settle();
    end

    repeat (40) @(posedge clk);
    if (board.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

// ===== stamped_slot_two_class_queue.f =====
rtl/sstcq_pkg.sv
rtl/sstcq_ctrl.sv
rtl/sstcq_datapath.sv
rtl/stamped_slot_two_class_queue.sv
tb/tb_top.sv
